FILE: hw/rtl/lcmh_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcmh_pkg
// Shared constants for the light change and motion hold block.
// ----------------------------------------------------------------------------
package lcmh_pkg;

	// Defaults for the top-level parameters
	localparam int DEF_RECENT_DEPTH = 4;
	localparam int DEF_SAMPLE_BITS  = 10;

	// Scaled light level
	localparam int           LEVEL_W     = 8;
	localparam logic [7:0]   LEVEL_RESET = 8'd128;
	localparam logic [7:0]   LEVEL_TOP   = 8'd255;
	localparam logic [7:0]   LEVEL_ZERO  = 8'd0;

	// Time fields
	localparam int ELAPSED_W = 32;
	localparam int MS_W      = 16;

	// Configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_LIGHT_MIN      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LIGHT_MAX      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_READ_PERIOD_MS = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_MOTION_HOLD_MS = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_MOTION_ENABLE  = 3'd4;

	// Register reset values
	localparam logic [MS_W-1:0] RST_READ_PERIOD_MS = 16'd1000;
	localparam logic [MS_W-1:0] RST_MOTION_HOLD_MS = 16'd30000;

endpackage

FILE: hw/rtl/lcmh_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcmh_tick_if / lcmh_result_if
// Valid/ready channels for input ticks and result transactions.
// ----------------------------------------------------------------------------
interface lcmh_tick_if #(
	parameter int SAMPLE_BITS = lcmh_pkg::DEF_SAMPLE_BITS
);
	logic                      valid;
	logic                      ready;
	logic [15:0]               dt_ms;
	logic [SAMPLE_BITS-1:0]    light_raw;
	logic                      motion_pin;
	logic                      take_change;

	modport source (output valid, output dt_ms, output light_raw, output motion_pin,
		output take_change, input ready);
	modport sink (input valid, input dt_ms, input light_raw, input motion_pin,
		input take_change, output ready);
endinterface

interface lcmh_result_if;
	logic       valid;
	logic       ready;
	logic [7:0] light_level;
	logic       big_change;
	logic       motion_detected;
	logic       sampled;

	modport source (output valid, output light_level, output big_change,
		output motion_detected, output sampled, input ready);
	modport sink (input valid, input light_level, input big_change,
		input motion_detected, input sampled, output ready);
endinterface

FILE: hw/rtl/lcmh_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcmh_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lcmh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

FILE: hw/rtl/light_change_and_motion_hold.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// light_change_and_motion_hold
// Light level change detector with a motion hold timer, one tick per
// transaction, built around one shared subtractor under a small sequencer.
// ----------------------------------------------------------------------------
// Usage:
//   tick   (sink)  : one transaction per timer tick: dt_ms, light_raw,
//                    motion_pin, take_change. tick.ready is high only while
//                    the sequencer is idle, so the block takes one tick at a time.
//   result (source): exactly one transaction per tick, held in an output
//                    register until result.ready takes it.
//   cfg_we/cfg_idx/cfg_data: register writes, one per clock, no read-back.
//                    Write only while no tick is in flight.
// Sequence, from tick acceptance to result valid: accumulate, period compare,
//   motion update and finish when the tick takes no light sample; a sampling
//   tick puts the clamp, the restoring divide for the scale, a ring read and
//   compare per entry searched and the ring update on a miss before motion,
//   with the search ending when the level is found and no divide when the
//   clamp settles the level. The shared 33-bit subtractor (period compare,
//   divide step, ring compare, hold countdown) and one RAM read port serialize them.
// Reset: control and state registers reset at once; the ring reads
//   as all zero through per-entry valid bits, so no clearing pass is needed.
// Stall: a finished result waits in the output register while the block
//   takes the next tick; if that tick finishes too, it waits in the last
//   state until the output register is free.
// ----------------------------------------------------------------------------
module light_change_and_motion_hold
	import lcmh_pkg::*;
#(
	parameter int RECENT_DEPTH = DEF_RECENT_DEPTH,
	parameter int SAMPLE_BITS  = DEF_SAMPLE_BITS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [CFG_IDX_W-1:0]    cfg_idx,
	input  logic [CFG_DATA_W-1:0]   cfg_data,
	lcmh_tick_if.sink               tick,
	lcmh_result_if.source           result
);

	localparam int PTR_W = (RECENT_DEPTH > 1) ? $clog2(RECENT_DEPTH) : 1;
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RECENT_DEPTH - 1);
	localparam int SB = SAMPLE_BITS;

	// Sequencer states
	localparam logic [3:0] ST_IDLE     = 4'd0;
	localparam logic [3:0] ST_ACC      = 4'd1;
	localparam logic [3:0] ST_CMP      = 4'd2;
	localparam logic [3:0] ST_CLAMP    = 4'd3;
	localparam logic [3:0] ST_DIV      = 4'd4;
	localparam logic [3:0] ST_SCAN_RD  = 4'd5;
	localparam logic [3:0] ST_SCAN_CMP = 4'd6;
	localparam logic [3:0] ST_UPDATE   = 4'd7;
	localparam logic [3:0] ST_MOTION   = 4'd8;
	localparam logic [3:0] ST_FINISH   = 4'd9;

	logic [3:0] state_q;

	// Configuration registers
	logic [SB-1:0]   light_min_q;
	logic [SB-1:0]   light_max_q;
	logic [MS_W-1:0] read_period_q;
	logic [MS_W-1:0] hold_ms_q;
	logic            motion_en_q;

	// Latched tick
	logic [MS_W-1:0] dt_q;
	logic [SB-1:0]   raw_q;
	logic            pin_q;
	logic            take_q;
	logic            sampled_q;

	// Block state
	logic [ELAPSED_W-1:0] elapsed_q;
	logic [LEVEL_W-1:0]   level_q;
	logic [RECENT_DEPTH-1:0] valid_q;
	logic [PTR_W-1:0]     ptr_q;
	logic                 change_q;
	logic                 motion_q;
	logic [MS_W-1:0]      hold_q;

	// Divider and scan working registers
	logic [SB-1:0]        rem_q;
	logic [LEVEL_W-1:0]   quot_q;
	logic [2:0]           div_cnt_q;
	logic [PTR_W-1:0]     scan_idx_q;

	// Output register
	logic                 out_vld_q;
	logic [LEVEL_W-1:0]   out_level_q;
	logic                 out_change_q;
	logic                 out_motion_q;
	logic                 out_sampled_q;

	// Shared subtractor
	logic [ELAPSED_W-1:0] sub_a;
	logic [ELAPSED_W-1:0] sub_b;
	logic [ELAPSED_W:0]   sub_res;
	logic                 sub_borrow;
	logic [ELAPSED_W-1:0] sub_diff;

	// Miscellaneous datapath
	logic [ELAPSED_W:0]   acc_sum;
	logic [ELAPSED_W-1:0] acc_sat;
	logic [SB-1:0]        span;
	logic [SB:0]          trial;
	logic [SB-1:0]        clamp_x;
	logic [SB-1:0]        clamp_diff;
	logic [SB+7:0]        scaled_num;
	logic [LEVEL_W-1:0]   ram_rdata;
	logic [LEVEL_W-1:0]   entry;
	logic                 ram_we;
	logic                 tick_acc;
	logic                 out_load;

	assign tick_acc = tick.valid && tick.ready;
	assign tick.ready = (state_q == ST_IDLE);
	assign out_load = (state_q == ST_FINISH) && (!out_vld_q || result.ready);
	assign ram_we = (state_q == ST_UPDATE);

	// Saturating millisecond accumulator
	assign acc_sum = {1'b0, elapsed_q} + {{(ELAPSED_W + 1 - MS_W){1'b0}}, dt_q};
	assign acc_sat = acc_sum[ELAPSED_W] ? {ELAPSED_W{1'b1}} : acc_sum[ELAPSED_W-1:0];

	// Clamp and scale numerator: (x - lo) * 255 = ((x - lo) << 8) - (x - lo)
	assign span = light_max_q - light_min_q;
	always_comb begin
		priority if (raw_q < light_min_q) begin
			clamp_x = light_min_q;
		end else if (raw_q > light_max_q) begin
			clamp_x = light_max_q;
		end else begin
			clamp_x = raw_q;
		end
	end
	assign clamp_diff = clamp_x - light_min_q;
	assign scaled_num = {clamp_diff, 8'd0} - {8'd0, clamp_diff};

	// Divide step operand: shift the next numerator bit into the remainder
	assign trial = {rem_q, quot_q[LEVEL_W-1]};

	// A ring entry never written reads as zero
	assign entry = valid_q[scan_idx_q] ? ram_rdata : LEVEL_ZERO;

	// Steer the shared subtractor by state
	always_comb begin
		unique case (state_q)
			ST_CMP: begin
				sub_a = elapsed_q;
				sub_b = {{(ELAPSED_W - MS_W){1'b0}}, read_period_q};
			end
			ST_DIV: begin
				sub_a = {{(ELAPSED_W - SB - 1){1'b0}}, trial};
				sub_b = {{(ELAPSED_W - SB){1'b0}}, span};
			end
			ST_SCAN_CMP: begin
				sub_a = {{(ELAPSED_W - LEVEL_W){1'b0}}, entry};
				sub_b = {{(ELAPSED_W - LEVEL_W){1'b0}}, level_q};
			end
			ST_MOTION: begin
				sub_a = {{(ELAPSED_W - MS_W){1'b0}}, hold_q};
				sub_b = {{(ELAPSED_W - MS_W){1'b0}}, dt_q};
			end
			default: begin
				sub_a = '0;
				sub_b = '0;
			end
		endcase
	end
	assign sub_res    = {1'b0, sub_a} - {1'b0, sub_b};
	assign sub_borrow = sub_res[ELAPSED_W];
	assign sub_diff   = sub_res[ELAPSED_W-1:0];

	// Ring of recent levels
	lcmh_ram #(
		.WIDTH (LEVEL_W),
		.DEPTH (RECENT_DEPTH)
	) u_ring (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ptr_q),
		.wdata (level_q),
		.raddr (scan_idx_q),
		.rdata (ram_rdata)
	);

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			light_min_q   <= '0;
			light_max_q   <= '1;
			read_period_q <= RST_READ_PERIOD_MS;
			hold_ms_q     <= RST_MOTION_HOLD_MS;
			motion_en_q   <= 1'b1;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_LIGHT_MIN:      light_min_q   <= cfg_data[SB-1:0];
				REG_LIGHT_MAX:      light_max_q   <= cfg_data[SB-1:0];
				REG_READ_PERIOD_MS: read_period_q <= cfg_data[MS_W-1:0];
				REG_MOTION_HOLD_MS: hold_ms_q     <= cfg_data[MS_W-1:0];
				REG_MOTION_ENABLE:  motion_en_q   <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// Latch the tick payload on acceptance
	always_ff @(posedge clk) begin
		if (tick_acc) begin
			dt_q   <= tick.dt_ms;
			raw_q  <= tick.light_raw;
			pin_q  <= tick.motion_pin;
			take_q <= tick.take_change;
		end
	end

	// Sequencer and block state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			elapsed_q  <= '0;
			level_q    <= LEVEL_RESET;
			valid_q    <= '0;
			ptr_q      <= '0;
			change_q   <= 1'b0;
			motion_q   <= 1'b0;
			hold_q     <= '0;
			sampled_q  <= 1'b0;
			div_cnt_q  <= '0;
			scan_idx_q <= '0;
			rem_q      <= '0;
			quot_q     <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (tick_acc) begin
						sampled_q <= 1'b0;
						state_q   <= ST_ACC;
					end
				end
				ST_ACC: begin
					elapsed_q <= acc_sat;
					state_q   <= ST_CMP;
				end
				ST_CMP: begin
					// Period reached: clear the accumulator and take a sample
					if (!sub_borrow) begin
						elapsed_q  <= '0;
						sampled_q  <= 1'b1;
						scan_idx_q <= '0;
						state_q    <= ST_CLAMP;
					end else begin
						state_q <= ST_MOTION;
					end
				end
				ST_CLAMP: begin
					priority if (light_min_q == light_max_q) begin
						level_q <= LEVEL_ZERO;
						state_q <= ST_SCAN_RD;
					end else if (light_min_q > light_max_q) begin
						// Inverted window: below min scales to zero, else to top
						level_q <= (raw_q < light_min_q) ? LEVEL_ZERO : LEVEL_TOP;
						state_q <= ST_SCAN_RD;
					end else begin
						rem_q     <= scaled_num[SB+7:8];
						quot_q    <= scaled_num[7:0];
						div_cnt_q <= '0;
						state_q   <= ST_DIV;
					end
				end
				ST_DIV: begin
					rem_q     <= sub_borrow ? trial[SB-1:0] : sub_diff[SB-1:0];
					quot_q    <= {quot_q[LEVEL_W-2:0], ~sub_borrow};
					div_cnt_q <= div_cnt_q + 3'd1;
					if (div_cnt_q == 3'd7) begin
						level_q <= {quot_q[LEVEL_W-2:0], ~sub_borrow};
						state_q <= ST_SCAN_RD;
					end
				end
				ST_SCAN_RD: begin
					state_q <= ST_SCAN_CMP;
				end
				ST_SCAN_CMP: begin
					priority if (sub_diff == '0) begin
						state_q <= ST_MOTION;
					end else if (scan_idx_q == PTR_LAST) begin
						state_q <= ST_UPDATE;
					end else begin
						scan_idx_q <= scan_idx_q + PTR_W'(1);
						state_q    <= ST_SCAN_RD;
					end
				end
				ST_UPDATE: begin
					// New level: flag the change and push it into the ring
					change_q       <= 1'b1;
					valid_q[ptr_q] <= 1'b1;
					ptr_q          <= (ptr_q == PTR_LAST) ? '0 : ptr_q + PTR_W'(1);
					state_q        <= ST_MOTION;
				end
				ST_MOTION: begin
					priority if (!motion_en_q) begin
						motion_q <= 1'b0;
						hold_q   <= '0;
					end else if (pin_q) begin
						motion_q <= 1'b1;
						hold_q   <= hold_ms_q;
					end else if (motion_q) begin
						// Count down; drop the flag when the hold runs out
						if (sub_borrow || sub_diff == '0) begin
							hold_q   <= '0;
							motion_q <= 1'b0;
						end else begin
							hold_q <= sub_diff[MS_W-1:0];
						end
					end
					state_q <= ST_FINISH;
				end
				ST_FINISH: begin
					if (out_load) begin
						if (take_q) begin
							change_q <= 1'b0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (out_load) begin
			out_vld_q <= 1'b1;
		end else if (result.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			out_level_q   <= level_q;
			out_change_q  <= change_q;
			out_motion_q  <= motion_q;
			out_sampled_q <= sampled_q;
		end
	end

	assign result.valid           = out_vld_q;
	assign result.light_level     = out_level_q;
	assign result.big_change      = out_change_q;
	assign result.motion_detected = out_motion_q;
	assign result.sampled         = out_sampled_q;

`ifndef SYNTH
	// One tick at a time: after acceptance the block stays busy
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		tick_acc |=> !tick.ready)
		else $error("tick accepted while a tick was in flight");

	// A sampling tick clears the accumulator
	a_elapsed_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_CMP && !sub_borrow) |=> (elapsed_q == '0 && sampled_q))
		else $error("accumulator not cleared on sample");

	// A ring write always raises the change flag
	a_change_on_write: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |=> change_q)
		else $error("ring written without change flag");

	// Disabled motion tracking leaves the flag and countdown at zero
	a_motion_disabled: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MOTION && !motion_en_q) |=> (!motion_q && hold_q == '0))
		else $error("motion state set while disabled");

	// A loaded result reports the current level
	a_result_level: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |=> (out_vld_q && out_level_q == $past(level_q)))
		else $error("result level differs from current level");
`endif

endmodule

FILE: bench/lcmh_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lcmh_checker
// Watches the config port and both channels, predicts one report per tick
// from its own copy of the state, and compares each report field by field.
// ----------------------------------------------------------------------------
module lcmh_checker
	import lcmh_pkg::*;
#(
	parameter int RECENT_DEPTH = DEF_RECENT_DEPTH,
	parameter int SAMPLE_BITS  = DEF_SAMPLE_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  logic [CFG_IDX_W-1:0]  cfg_idx,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	lcmh_tick_if                  tick_ch,
	lcmh_result_if                res_ch,
	output int                    miscompares,
	output int                    outstanding
);

	typedef struct packed {
		logic [LEVEL_W-1:0] light_level;
		logic               big_change;
		logic               motion_detected;
		logic               sampled;
	} light_report_t;

	// Register copies
	logic [SAMPLE_BITS-1:0] lim_lo;
	logic [SAMPLE_BITS-1:0] lim_hi;
	logic [MS_W-1:0]        period;
	logic [MS_W-1:0]        hold_cfg;
	logic                   motion_on;

	// Block state
	logic [ELAPSED_W-1:0]   elapsed;
	logic [LEVEL_W-1:0]     level;
	logic [LEVEL_W-1:0]     recent [RECENT_DEPTH];
	int                     ring_wr;
	logic                   change;
	logic                   motion;
	logic [ELAPSED_W-1:0]   hold_left;

	light_report_t reports_due [$];

	initial miscompares = 0;

	task automatic report_miss(input string what, input int want_v, input int got_v);
		miscompares++;
		$display("[%0t] %s: expected %0d, got %0d", $time, what, want_v, got_v);
	endtask

	function automatic logic [LEVEL_W-1:0] scale_light(input logic [SAMPLE_BITS-1:0] raw);
		int lo;
		int hi;
		int x;
		int span;
		int r;
		lo = lim_lo;
		hi = lim_hi;
		x  = raw;
		if (x < lo) begin
			x = lo;
		end else if (x > hi) begin
			x = hi;
		end
		span = hi - lo;
		if (span == 0) begin
			return LEVEL_ZERO;
		end
		r = ((x - lo) * 255) / span;
		if (r < 0) r = 0;
		if (r > 255) r = 255;
		return r[LEVEL_W-1:0];
	endfunction

	task automatic predict_tick(input logic [MS_W-1:0] dt, input logic [SAMPLE_BITS-1:0] raw,
		input logic pin, input logic take);
		light_report_t          rep;
		logic                   found;
		logic [ELAPSED_W:0]     sum;
		int                     i;
		rep = '0;
		sum = {1'b0, elapsed} + dt;
		elapsed = sum[ELAPSED_W] ? '1 : sum[ELAPSED_W-1:0];
		if (elapsed >= period) begin
			elapsed     = '0;
			rep.sampled = 1'b1;
			level       = scale_light(raw);
			found       = 1'b0;
			for (i = 0; i < RECENT_DEPTH; i++) begin
				if (recent[i] == level) found = 1'b1;
			end
			if (!found) begin
				change          = 1'b1;
				recent[ring_wr] = level;
				ring_wr         = (ring_wr + 1) % RECENT_DEPTH;
			end
		end
		if (!motion_on) begin
			motion    = 1'b0;
			hold_left = '0;
		end else if (pin) begin
			motion    = 1'b1;
			hold_left = hold_cfg;
		end else if (motion) begin
			hold_left = (hold_left > dt) ? hold_left - dt : '0;
			if (hold_left == 0) motion = 1'b0;
		end
		rep.light_level     = level;
		rep.big_change      = change;
		rep.motion_detected = motion;
		reports_due.push_back(rep);
		if (take) change = 1'b0;
	endtask

	task automatic check_report();
		light_report_t want;
		light_report_t got;
		got = '{res_ch.light_level, res_ch.big_change, res_ch.motion_detected, res_ch.sampled};
		if (reports_due.size() == 0) begin
			report_miss("result with no tick waiting, light_level", -1, got.light_level);
			return;
		end
		want = reports_due.pop_front();
		if (got.light_level !== want.light_level)
			report_miss("light_level", want.light_level, got.light_level);
		if (got.big_change !== want.big_change)
			report_miss("big_change", want.big_change, got.big_change);
		if (got.motion_detected !== want.motion_detected)
			report_miss("motion_detected", want.motion_detected, got.motion_detected);
		if (got.sampled !== want.sampled)
			report_miss("sampled", want.sampled, got.sampled);
	endtask

	always @(posedge clk) begin
		if (!arst_n) begin
			lim_lo    <= '0;
			lim_hi    <= '1;
			period    <= RST_READ_PERIOD_MS;
			hold_cfg  <= RST_MOTION_HOLD_MS;
			motion_on <= 1'b1;
			elapsed   = '0;
			level     = LEVEL_RESET;
			for (int i = 0; i < RECENT_DEPTH; i++) recent[i] = '0;
			ring_wr   = 0;
			change    = 1'b0;
			motion    = 1'b0;
			hold_left = '0;
			reports_due.delete();
			outstanding <= 0;
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					REG_LIGHT_MIN:      lim_lo    <= cfg_data[SAMPLE_BITS-1:0];
					REG_LIGHT_MAX:      lim_hi    <= cfg_data[SAMPLE_BITS-1:0];
					REG_READ_PERIOD_MS: period    <= cfg_data[MS_W-1:0];
					REG_MOTION_HOLD_MS: hold_cfg  <= cfg_data[MS_W-1:0];
					REG_MOTION_ENABLE:  motion_on <= cfg_data[0];
					default: ;
				endcase
			end
			if (res_ch.valid && res_ch.ready) check_report();
			if (tick_ch.valid && tick_ch.ready) begin
				predict_tick(tick_ch.dt_ms, tick_ch.light_raw, tick_ch.motion_pin,
					tick_ch.take_change);
			end
			outstanding <= reports_due.size();
		end
	end

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the light change and motion hold block: a directed pass over
// the clamp and scale corners, ring wrap, hold expiry and disabled motion,
// then random phases under several register settings with random idling on
// both channels. The checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_top;
	import lcmh_pkg::*;

	localparam int RECENT_DEPTH = DEF_RECENT_DEPTH;
	localparam int SAMPLE_BITS  = DEF_SAMPLE_BITS;
	// Worst sampling tick, used as the linger after each drain
	localparam int LATENCY_MAX  = 14 + 2 * RECENT_DEPTH;
	localparam int LONG_HOLD    = 300;
	localparam int QUIET_LIMIT  = 4000;
	localparam int PHASES       = 7;
	localparam int PHASE_TICKS  = 200;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_idx;
	logic [CFG_DATA_W-1:0] cfg_data;

	lcmh_tick_if #(.SAMPLE_BITS(SAMPLE_BITS)) tick_ch ();
	lcmh_result_if                            res_ch ();

	int miscompares;
	int outstanding;
	int quiet_cycles;

	// Stimulus shaping state
	bit                     calm;
	bit                     long_hold_req;
	int                     burst_left;
	bit                     pin_now;
	int                     cur_lo;
	int                     cur_period;
	logic [SAMPLE_BITS-1:0] raw_pool [6];

	light_change_and_motion_hold #(
		.RECENT_DEPTH(RECENT_DEPTH),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_we  (cfg_we),
		.cfg_idx (cfg_idx),
		.cfg_data(cfg_data),
		.tick    (tick_ch),
		.result  (res_ch)
	);

	lcmh_checker #(
		.RECENT_DEPTH(RECENT_DEPTH),
		.SAMPLE_BITS (SAMPLE_BITS)
	) u_check (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_idx    (cfg_idx),
		.cfg_data   (cfg_data),
		.tick_ch    (tick_ch),
		.res_ch     (res_ch),
		.miscompares(miscompares),
		.outstanding(outstanding)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Watchdog: end the run if no transaction moves on either channel for too long
	always @(posedge clk) begin
		if (arst_n) begin
			if ((tick_ch.valid && tick_ch.ready) || (res_ch.valid && res_ch.ready)) begin
				quiet_cycles <= 0;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("end of test: mismatches");
				$finish;
			end
		end else begin
			quiet_cycles <= 0;
		end
	end

	// Result side: random stalls, one long hold on request, none once calm
	initial begin
		res_ch.ready <= 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (long_hold_req) begin
				// Hold off long enough for the block to fill and stall its input
				long_hold_req = 1'b0;
				res_ch.ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
			end else if (!calm && $urandom_range(0, 2) == 0) begin
				res_ch.ready <= 1'b0;
				repeat ($urandom_range(1, 14)) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			repeat ($urandom_range(1, calm ? 1 : 24)) @(posedge clk);
		end
	end

	// Offer one tick and hold it until the block takes it. Valid stays high
	// afterwards so back-to-back ticks never drop it for a step.
	task automatic send_tick(input logic [MS_W-1:0] dt, input logic [SAMPLE_BITS-1:0] raw,
		input logic pin, input logic take);
		if (burst_left > 0) begin
			burst_left--;
		end else if (!calm && $urandom_range(0, 3) == 0) begin
			tick_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 14)) @(posedge clk);
		end
		tick_ch.valid       <= 1'b1;
		tick_ch.dt_ms       <= dt;
		tick_ch.light_raw   <= raw;
		tick_ch.motion_pin  <= pin;
		tick_ch.take_change <= take;
		do @(posedge clk); while (!tick_ch.ready);
	endtask

	// Drop valid and wait until every report has come back, then linger
	task automatic wait_drained(input int linger);
		tick_ch.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (linger) @(posedge clk);
	endtask

	// Write all five registers on consecutive edges with the enable held high
	task automatic set_config(input int lo, input int hi, input int period, input int hold,
		input bit en);
		cur_lo     = lo;
		cur_period = period;
		cfg_we   <= 1'b1;
		cfg_idx  <= REG_LIGHT_MIN;
		cfg_data <= CFG_DATA_W'(lo);
		@(posedge clk);
		cfg_idx  <= REG_LIGHT_MAX;
		cfg_data <= CFG_DATA_W'(hi);
		@(posedge clk);
		cfg_idx  <= REG_READ_PERIOD_MS;
		cfg_data <= CFG_DATA_W'(period);
		@(posedge clk);
		cfg_idx  <= REG_MOTION_HOLD_MS;
		cfg_data <= CFG_DATA_W'(hold);
		@(posedge clk);
		cfg_idx  <= REG_MOTION_ENABLE;
		cfg_data <= CFG_DATA_W'(en);
		@(posedge clk);
		cfg_we   <= 1'b0;
	endtask

	// Pick the register setting for one random phase; the fixed ones hit the extremes
	task automatic start_phase(input int k);
		int lo;
		int hi;
		int i;
		case (k)
			0: begin
				lo = $urandom_range(0, 400);
				hi = $urandom_range(600, 1023);
				set_config(lo, hi, $urandom_range(1, 1500), $urandom_range(1, 4000), 1'b1);
			end
			1: set_config(0, 1023, 1, 1, 1'b1);
			2: begin
				lo = $urandom_range(0, 1023);
				set_config(lo, lo, $urandom_range(1, 800), $urandom_range(1, 3000), 1'b0);
			end
			3: begin
				lo = $urandom_range(512, 1023);
				set_config(lo, $urandom_range(0, 511), 65535, 65535, 1'b1);
			end
			default: begin
				set_config($urandom_range(0, 1023), $urandom_range(0, 1023),
					$urandom_range(1, 3000), $urandom_range(1, 5000),
					$urandom_range(0, 3) != 0);
			end
		endcase
		// A small pool of samples per phase so levels repeat and hit the ring
		for (i = 0; i < 6; i++) raw_pool[i] = SAMPLE_BITS'($urandom_range(0, 1023));
	endtask

	task automatic random_tick();
		logic [MS_W-1:0]        dt;
		logic [SAMPLE_BITS-1:0] raw;
		int                     sel;
		int                     dt_top;
		dt_top = 2 * cur_period;
		if (dt_top > 65535) dt_top = 65535;
		sel = $urandom_range(0, 9);
		case (sel)
			0:       dt = '0;
			1:       dt = '1;
			2, 3:    dt = MS_W'($urandom);
			default: dt = MS_W'($urandom_range(0, dt_top));
		endcase
		sel = $urandom_range(0, 7);
		case (sel)
			0, 1, 2: raw = raw_pool[$urandom_range(0, 5)];
			3:       raw = '0;
			4:       raw = '1;
			5:       raw = SAMPLE_BITS'(cur_lo);
			default: raw = SAMPLE_BITS'($urandom);
		endcase
		// Motion arrives in runs so the hold countdown gets to expire
		if ($urandom_range(0, 5) == 0) pin_now = ~pin_now;
		send_tick(dt, raw, pin_now, 1'($urandom_range(0, 1)));
	endtask

	initial begin
		int k;
		int n;
		arst_n              <= 1'b0;
		cfg_we              <= 1'b0;
		cfg_idx             <= REG_LIGHT_MIN;
		cfg_data            <= '0;
		tick_ch.valid       <= 1'b0;
		tick_ch.dt_ms       <= '0;
		tick_ch.light_raw   <= '0;
		tick_ch.motion_pin  <= 1'b0;
		tick_ch.take_change <= 1'b0;
		calm          = 1'b0;
		long_hold_req = 1'b0;
		burst_left    = 0;
		pin_now       = 1'b0;
		cur_lo        = 0;
		cur_period    = RST_READ_PERIOD_MS;

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset settings: accumulate to the period, ring hits and misses, ring wrap,
		// hold countdown running out, take clearing the sticky flag
		send_tick(16'd0,     10'd0,    1'b0, 1'b0);
		send_tick(16'd1000,  10'd1023, 1'b1, 1'b0);
		send_tick(16'd65535, 10'd0,    1'b0, 1'b1);
		send_tick(16'd999,   10'd512,  1'b0, 1'b0);
		send_tick(16'd1,     10'd512,  1'b0, 1'b1);
		send_tick(16'd1000,  10'd512,  1'b1, 1'b1);
		send_tick(16'd29999, 10'd300,  1'b0, 1'b0);
		send_tick(16'd1,     10'd300,  1'b0, 1'b0);
		send_tick(16'd1000,  10'd1023, 1'b0, 1'b0);
		send_tick(16'd1000,  10'd700,  1'b0, 1'b0);
		send_tick(16'd1000,  10'd100,  1'b0, 1'b1);
		send_tick(16'd1000,  10'd1023, 1'b0, 1'b0);
		wait_drained(LATENCY_MAX);

		// Equal min and max: zero span forces level zero; shortest hold runs out
		set_config(300, 300, 1, 1, 1'b1);
		send_tick(16'd1, 10'd0,    1'b1, 1'b1);
		send_tick(16'd0, 10'd1023, 1'b0, 1'b0);
		send_tick(16'd5, 10'd300,  1'b0, 1'b0);
		wait_drained(LATENCY_MAX);

		// Min above max with motion disabled: pin is ignored
		set_config(800, 200, 65535, 65535, 1'b0);
		send_tick(16'd65535, 10'd799,  1'b1, 1'b0);
		send_tick(16'd65535, 10'd800,  1'b1, 1'b1);
		send_tick(16'd65534, 10'd1023, 1'b0, 1'b0);
		send_tick(16'd1,     10'd0,    1'b0, 1'b0);
		wait_drained(LATENCY_MAX);

		// Widest inverted range and longest hold
		set_config(1023, 0, 1, 65535, 1'b1);
		send_tick(16'd65535, 10'd1023, 1'b1, 1'b1);
		send_tick(16'd1,     10'd1022, 1'b0, 1'b0);
		send_tick(16'd65535, 10'd0,    1'b0, 1'b1);
		wait_drained(LATENCY_MAX);

		// Random phases; the last one runs with no idling on either side
		for (k = 0; k < PHASES; k++) begin
			start_phase(k);
			if (k == PHASES - 1) calm = 1'b1;
			for (n = 0; n < PHASE_TICKS; n++) begin
				if (k == 0 && n == 50) begin
					// Stall the result side while ticks keep coming back to back
					long_hold_req = 1'b1;
					burst_left    = 20;
				end
				if (k == 0 && n == 120) begin
					// Pause the tick side until every report is back
					wait_drained(0);
				end
				random_tick();
			end
			wait_drained(LATENCY_MAX);
		end

		if (miscompares == 0 && outstanding == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

endmodule

FILE: files.f
hw/rtl/lcmh_pkg.sv
hw/rtl/lcmh_if.sv
hw/rtl/lcmh_ram.sv
hw/rtl/light_change_and_motion_hold.sv
bench/lcmh_checker.sv
bench/tb_top.sv
